// ===== sv/hse_pkg.sv =====
// shared types for the heap sort engine
package hse_pkg;

   // input item: one element of the set
   typedef struct packed {
      logic signed [31:0] value;
      logic               last_in;
   } req_payload_type;

   // result item: one sorted element
   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_out;
      logic               overflowed;
   } rsp_payload_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_BUILD_NEXT,
      ST_BUILD_CUR,
      ST_SIFT_ISSUE,
      ST_SIFT_LEFT,
      ST_SIFT_RIGHT,
      ST_EXT_NEXT,
      ST_EXT_LASTV,
      ST_EXT_ROOT,
      ST_OUT_LOAD
   } hse_state_type;

   // which sort pass a sift-down returns to
   typedef enum logic {
      PH_BUILD,
      PH_EXTRACT
   } hse_phase_type;

endpackage

// ===== sv/heap_sort_engine_top.sv =====
// heap sort engine: loads a set into a store, heap-sorts it in place and streams it out
// Loading accepts one item per cycle; items are stalled while a set is sorted or emitted.
// Sorting is done by one sift-down sequencer on a store with one write port and a registered read port:
// each tree level reads the left child, then the right child if there is one, then compares and writes back,
// with about n/2 + n - 1 sift-downs; each root extraction first reads the heap end and then the root.
// Results then follow one per cycle unless the receiver stalls. Reset clears the count, overflow flag,
// sequencer and output valid; the store itself is not cleared and needs no clearing pass.
module heap_sort_engine_top
   import hse_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int IW = CW + 1;

   // element store
   logic signed [31:0] mem [MAX_ELEMENTS];
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic signed [31:0] mem_wdata;
   logic [AW-1:0]      mem_raddr;
   logic signed [31:0] rd_data_ff;

   // control and datapath registers
   hse_state_type      state_ff, state_in;
   hse_phase_type      phase_ff, phase_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [AW-1:0]      node_ff, node_in;
   logic [CW-1:0]      size_ff, size_in;
   logic [CW-1:0]      bidx_ff, bidx_in;
   logic [CW-1:0]      end_ff, end_in;
   logic [CW-1:0]      k_ff, k_in;
   logic signed [31:0] cur_ff, cur_in;
   logic signed [31:0] left_ff, left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   // shared decode
   logic               full;
   logic [CW-1:0]      count_next;
   logic [IW-1:0]      left_idx;
   logic [IW-1:0]      right_idx;
   logic               has_left;
   logic               has_right;
   logic               decide;
   logic signed [31:0] pick_val;
   logic [IW-1:0]      pick_idx;
   logic               cur_wins;
   logic               out_free;
   logic               out_last;
   logic [CW-1:0]      k_next;
   hse_state_type      ret_state;

   assign full       = (count_ff == CW'(MAX_ELEMENTS));
   assign count_next = full ? count_ff : count_ff + CW'(1);
   assign left_idx   = IW'({node_ff, 1'b0}) + IW'(1);
   assign right_idx  = left_idx + IW'(1);
   assign has_left   = (left_idx < IW'(size_ff));
   assign has_right  = (right_idx < IW'(size_ff));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign k_next     = k_ff + CW'(1);
   assign out_last   = (k_next == count_ff);
   assign ret_state  = (phase_ff == PH_BUILD) ? ST_BUILD_NEXT : ST_EXT_NEXT;

   // child selection: larger child, right only when strictly greater
   always_comb begin
      decide   = 1'b0;
      pick_val = rd_data_ff;
      pick_idx = left_idx;
      if (state_ff == ST_SIFT_LEFT) begin
         decide = !has_right;
      end else if (state_ff == ST_SIFT_RIGHT) begin
         decide = 1'b1;
         if (rd_data_ff > left_ff) begin
            pick_val = rd_data_ff;
            pick_idx = right_idx;
         end else begin
            pick_val = left_ff;
            pick_idx = left_idx;
         end
      end
   end

   assign cur_wins = (cur_ff > pick_val);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_payload.last_in) state_in = ST_BUILD_NEXT;
         end
         ST_BUILD_NEXT: begin
            state_in = (bidx_ff == '0) ? ST_EXT_NEXT : ST_BUILD_CUR;
         end
         ST_BUILD_CUR: state_in = ST_SIFT_ISSUE;
         ST_SIFT_ISSUE: begin
            state_in = has_left ? ST_SIFT_LEFT : ret_state;
         end
         ST_SIFT_LEFT: begin
            if (has_right) state_in = ST_SIFT_RIGHT;
            else           state_in = cur_wins ? ret_state : ST_SIFT_ISSUE;
         end
         ST_SIFT_RIGHT: state_in = cur_wins ? ret_state : ST_SIFT_ISSUE;
         ST_EXT_NEXT: begin
            state_in = (end_ff <= CW'(1)) ? ST_OUT_LOAD : ST_EXT_LASTV;
         end
         ST_EXT_LASTV: state_in = ST_EXT_ROOT;
         ST_EXT_ROOT: state_in = ST_SIFT_ISSUE;
         ST_OUT_LOAD: begin
            if (out_free && out_last) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath controls and register next values
   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      node_in        = node_ff;
      size_in        = size_ff;
      bidx_in        = bidx_ff;
      end_in         = end_ff;
      k_in           = k_ff;
      cur_in         = cur_ff;
      left_in        = left_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;
      mem_raddr      = '0;
      unique case (state_ff)
         // store the item, or drop it once the store is full
         ST_LOAD: begin
            if (req_valid) begin
               if (!full) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[AW-1:0];
                  mem_wdata = req_payload.value;
               end else begin
                  ovf_in = 1'b1;
               end
               count_in = count_next;
               if (req_payload.last_in) begin
                  size_in  = count_next;
                  end_in   = count_next;
                  bidx_in  = count_next >> 1;
                  phase_in = PH_BUILD;
               end
            end
         end
         // heap build: next inner node, counting down to the root
         ST_BUILD_NEXT: begin
            if (bidx_ff == '0) begin
               phase_in = PH_EXTRACT;
            end else begin
               bidx_in   = bidx_ff - CW'(1);
               node_in   = AW'(bidx_ff - CW'(1));
               mem_raddr = AW'(bidx_ff - CW'(1));
            end
         end
         ST_BUILD_CUR: cur_in = rd_data_ff;
         // sift-down: fetch left child or settle the value here
         ST_SIFT_ISSUE: begin
            if (has_left) begin
               mem_raddr = left_idx[AW-1:0];
            end else begin
               mem_we    = 1'b1;
               mem_waddr = node_ff;
               mem_wdata = cur_ff;
            end
         end
         ST_SIFT_LEFT, ST_SIFT_RIGHT: begin
            if (state_ff == ST_SIFT_LEFT) left_in = rd_data_ff;
            if (state_ff == ST_SIFT_LEFT && has_right) mem_raddr = right_idx[AW-1:0];
            if (decide) begin
               mem_we    = 1'b1;
               mem_waddr = node_ff;
               if (cur_wins) begin
                  mem_wdata = cur_ff;
               end else begin
                  mem_wdata = pick_val;
                  node_in   = pick_idx[AW-1:0];
               end
            end
         end
         // extraction: read end of heap, then root
         ST_EXT_NEXT: begin
            if (end_ff <= CW'(1)) begin
               k_in = '0;
            end else begin
               mem_raddr = AW'(end_ff - CW'(1));
            end
         end
         ST_EXT_LASTV: cur_in = rd_data_ff;
         // old root goes to the end, old end value sifts from the root
         ST_EXT_ROOT: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(end_ff - CW'(1));
            mem_wdata = rd_data_ff;
            end_in    = end_ff - CW'(1);
            size_in   = end_ff - CW'(1);
            node_in   = '0;
         end
         // stream out in ascending order
         ST_OUT_LOAD: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.sorted_value = rd_data_ff;
               rsp_payload_in.last_out     = out_last;
               rsp_payload_in.overflowed   = ovf_ff;
               k_in                        = k_next;
               mem_raddr                   = AW'(k_next);
               if (out_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end else begin
               mem_raddr = AW'(k_ff);
            end
         end
         default: ;
      endcase
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         phase_ff     <= PH_BUILD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      node_ff        <= node_in;
      size_ff        <= size_in;
      bidx_ff        <= bidx_in;
      end_ff         <= end_in;
      k_ff           <= k_in;
      cur_ff         <= cur_in;
      left_ff        <= left_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != ST_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== dv/heap_sort_engine_top_tb.sv =====
// self-checking testbench for the heap sort engine: random sets under idling, checked against a shadow heapsort
`timescale 1ns / 1ps
module heap_sort_engine_top_tb
   import hse_pkg::*;
();

   localparam int MAX_ELEMS   = 64;
   localparam int TAIL_CYCLES = 300;
   localparam int HOLD_CYCLES = 1500;
   localparam int ITEM_TARGET = 250;

   // how element values are drawn for a set
   typedef enum logic [1:0] {
      MIX_WIDE,
      MIX_NARROW,
      MIX_EDGE
   } value_mix_type;

   typedef struct {
      req_payload_type payload;
      int unsigned     gap;
      bit              drain_first;
   } pending_item_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   pending_item_type   pending_items[$];
   rsp_payload_type    sorted_expect[$];
   logic signed [31:0] shadow_store[MAX_ELEMS];
   int unsigned        shadow_count   = 0;
   bit                 shadow_dropped = 1'b0;
   int unsigned        error_count    = 0;
   int unsigned        items_taken    = 0;

   heap_sort_engine_top #(
      .MAX_ELEMENTS(MAX_ELEMS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #10 clock = ~clock;

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      else if (roll < 90) return $urandom_range(3, 1);
      else return $urandom_range(40, 8);
   endfunction

   function automatic logic signed [31:0] pick_value(value_mix_type mix);
      logic signed [31:0] v;
      case (mix)
         MIX_WIDE: begin
            v = $urandom;
         end
         MIX_NARROW: begin
            v = $signed($urandom_range(8)) - 4;
         end
         default: begin
            case ($urandom_range(4))
               0: v = 32'sh7fffffff;
               1: v = 32'sh80000000;
               2: v = 32'sh0;
               3: v = -32'sh1;
               default: v = $urandom;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic queue_item(logic signed [31:0] value, bit last, int unsigned gap, bit drain);
      pending_item_type item;
      item.payload.value   = value;
      item.payload.last_in = last;
      item.gap             = gap;
      item.drain_first     = drain;
      pending_items.push_back(item);
   endtask

   task automatic queue_set(int unsigned size, value_mix_type mix, bit drain, bit calm);
      for (int unsigned i = 0; i < size; i++) begin
         queue_item(pick_value(mix), i == size - 1, calm ? 0 : pick_gap(), drain && i == 0);
      end
   endtask

   // max-heap sift-down over the shadow store
   task automatic sift_shadow(int unsigned node, int unsigned size);
      int unsigned        pick;
      logic signed [31:0] tmp;
      bit                 settled;
      settled = 1'b0;
      while (!settled && node * 2 + 1 < size) begin
         pick = node * 2 + 1;
         if (pick + 1 < size && shadow_store[pick + 1] > shadow_store[pick]) pick = pick + 1;
         if (shadow_store[node] > shadow_store[pick]) begin
            settled = 1'b1;
         end else begin
            tmp                = shadow_store[node];
            shadow_store[node] = shadow_store[pick];
            shadow_store[pick] = tmp;
            node               = pick;
         end
      end
   endtask

   task automatic heapsort_shadow(int unsigned size);
      logic signed [31:0] tmp;
      for (int unsigned i = size / 2; i > 0; i--) sift_shadow(i - 1, size);
      for (int unsigned i = size; i > 1; i--) begin
         tmp                 = shadow_store[0];
         shadow_store[0]     = shadow_store[i - 1];
         shadow_store[i - 1] = tmp;
         sift_shadow(0, i - 1);
      end
   endtask

   // store an accepted item; on the end of a set, sort and queue its results
   task automatic absorb_item(req_payload_type item);
      rsp_payload_type res;
      if (shadow_count < MAX_ELEMS) begin
         shadow_store[shadow_count] = item.value;
         shadow_count++;
      end else begin
         shadow_dropped = 1'b1;
      end
      if (item.last_in) begin
         heapsort_shadow(shadow_count);
         for (int unsigned k = 0; k < shadow_count; k++) begin
            res.sorted_value = shadow_store[k];
            res.last_out     = (k + 1 == shadow_count);
            res.overflowed   = shadow_dropped;
            sorted_expect.push_back(res);
         end
         shadow_count   = 0;
         shadow_dropped = 1'b0;
      end
   endtask

   // driver: offers pending items with gaps, some only once all results are back
   int unsigned      gap_left  = 0;
   bit               gap_armed = 1'b0;
   pending_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_armed = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_item(req_payload);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               if (!gap_armed) begin
                  gap_left  = pending_items[0].gap;
                  gap_armed = 1'b1;
               end
               if (gap_left > 0) begin
                  gap_left--;
                  req_valid <= 1'b0;
               end else if (pending_items[0].drain_first && sorted_expect.size() != 0) begin
                  req_valid <= 1'b0;
               end else begin
                  next_item = pending_items.pop_front();
                  req_payload <= next_item.payload;
                  req_valid   <= 1'b1;
                  gap_armed = 1'b0;
               end
            end
         end
      end
   end

   // one long receiver hold-off while the sender keeps offering items
   int unsigned hold_left = 0;
   bit          hold_used = 1'b0;
   logic        hold_on   = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         hold_on <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         hold_on <= (hold_left != 0);
      end else if (!hold_used && rsp_valid && items_taken >= 40 && pending_items.size() != 0
                   && !pending_items[0].drain_first) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
         hold_on <= 1'b1;
      end else begin
         hold_on <= 1'b0;
      end
   end

   // monitor: checks each result item against the oldest expectation, stalls at random
   int unsigned     stall_left = 0;
   int unsigned     calm_left  = 0;
   int unsigned     rsp_roll;
   rsp_payload_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_expect.size() == 0) begin
               $error("result item with none expected: sorted_value %0d", rsp_payload.sorted_value);
               error_count++;
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_payload.sorted_value !== want.sorted_value) begin
                  $error("sorted_value: expected %0d, got %0d",
                         want.sorted_value, rsp_payload.sorted_value);
                  error_count++;
               end
               if (rsp_payload.last_out !== want.last_out) begin
                  $error("last_out: expected %0b, got %0b", want.last_out, rsp_payload.last_out);
                  error_count++;
               end
               if (rsp_payload.overflowed !== want.overflowed) begin
                  $error("overflowed: expected %0b, got %0b",
                         want.overflowed, rsp_payload.overflowed);
                  error_count++;
               end
            end
         end
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            rsp_roll = $urandom_range(99);
            if (rsp_roll < 10) calm_left = $urandom_range(120, 30);
            else if (rsp_roll < 35) stall_left = pick_gap();
         end
      end
   end

   // stimulus: directed sets, then random sets with a full and an overflowing store
   bit          full_done = 1'b0;
   bit          over_done = 1'b0;
   int unsigned set_size;

   initial begin
      // single element, most negative value
      queue_item(32'sh80000000, 1'b1, 0, 1'b0);
      // two elements, largest first
      queue_item(32'sh7fffffff, 1'b0, 0, 1'b1);
      queue_item(32'sh80000000, 1'b1, 0, 1'b0);
      // extremes, values around zero, duplicates
      queue_item(32'sh0, 1'b0, 0, 1'b1);
      queue_item(-32'sh1, 1'b0, 1, 1'b0);
      queue_item(32'sh1, 1'b0, 0, 1'b0);
      queue_item(32'sh7fffffff, 1'b0, 0, 1'b0);
      queue_item(32'sh80000000, 1'b0, 2, 1'b0);
      queue_item(32'sh5, 1'b0, 0, 1'b0);
      queue_item(32'sh5, 1'b0, 0, 1'b0);
      queue_item(-32'sh5, 1'b0, 0, 1'b0);
      queue_item(32'sh7ffffffe, 1'b0, 0, 1'b0);
      queue_item(32'sh80000001, 1'b0, 0, 1'b0);
      queue_item(32'sh1, 1'b1, 0, 1'b0);
      // already ascending
      for (int i = -3; i <= 3; i++) queue_item(i, i == 3, 0, i == -3);

      while (pending_items.size() < ITEM_TARGET) begin
         if (!full_done && pending_items.size() >= 60) begin
            set_size  = MAX_ELEMS;
            full_done = 1'b1;
         end else if (!over_done && pending_items.size() >= 150) begin
            // overflow: the dropped items include the one that ends the set
            set_size  = MAX_ELEMS + 1 + $urandom_range(2);
            over_done = 1'b1;
         end else begin
            set_size = $urandom_range(12, 1);
         end
         queue_set(set_size, value_mix_type'($urandom_range(2)),
                   $urandom_range(4) == 0, $urandom_range(3) == 0);
      end
   end

   // reset, then wait for all items and results, then a quiet tail
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_items.size() != 0 || req_valid || sorted_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== heap_sort_engine_top.f =====
sv/hse_pkg.sv
sv/heap_sort_engine_top.sv
dv/heap_sort_engine_top_tb.sv
